### design/rdlp_pkg.sv
package rdlp_pkg;

  localparam int unsigned COORD_WIDTH = 16;
  localparam int unsigned SIZE_W      = COORD_WIDTH - 1;
  localparam int unsigned EDGE_W      = COORD_WIDTH + 1;
  localparam int unsigned DIFF_W      = EDGE_W + 1;
  localparam int unsigned AREA_W      = 2 * SIZE_W;

  localparam int unsigned IN_BITS     = 4 * COORD_WIDTH + 4 * SIZE_W;
  localparam int unsigned IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = 2 * EDGE_W + 2 * SIZE_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int unsigned PART_W      = 3;

  typedef enum logic [PART_W-1:0] {
    KEPT_NONE   = 3'd0,
    KEPT_TOP    = 3'd1,
    KEPT_BOTTOM = 3'd2,
    KEPT_LEFT   = 3'd3,
    KEPT_RIGHT  = 3'd4,
    KEPT_EMPTY  = 3'd5
  } part_e;

  // The first field sits in the lowest bits, so it is declared last.
  typedef struct packed {
    logic        [SIZE_W-1:0]      b_height;
    logic        [SIZE_W-1:0]      b_width;
    logic signed [COORD_WIDTH-1:0] b_top;
    logic signed [COORD_WIDTH-1:0] b_left;
    logic        [SIZE_W-1:0]      a_height;
    logic        [SIZE_W-1:0]      a_width;
    logic signed [COORD_WIDTH-1:0] a_top;
    logic signed [COORD_WIDTH-1:0] a_left;
  } rect_pair_t;

  typedef struct packed {
    part_e                    part_kept;
    logic        [SIZE_W-1:0] out_height;
    logic        [SIZE_W-1:0] out_width;
    logic signed [EDGE_W-1:0] out_top;
    logic signed [EDGE_W-1:0] out_left;
  } rect_res_t;

endpackage

### design/rdlp_core.sv
module rdlp_core (
  input  rdlp_pkg::rect_pair_t pair_i,
  output rdlp_pkg::rect_res_t  res_o
);
  import rdlp_pkg::*;

  logic signed [EDGE_W-1:0] al, at, ar, ab, bl, bt, br, bb;
  logic signed [DIFF_W-1:0] d_top, d_bot, d_left, d_right;
  logic        [SIZE_W-1:0] s_top, s_bot, s_left, s_right;
  logic                     overlap, ct, cb, cl, cr, have;
  logic        [1:0]        best;
  logic        [3:0]        ok;
  logic        [AREA_W-1:0] val [4];

  always_comb begin
    al = {pair_i.a_left[COORD_WIDTH-1], pair_i.a_left};
    at = {pair_i.a_top[COORD_WIDTH-1], pair_i.a_top};
    bl = {pair_i.b_left[COORD_WIDTH-1], pair_i.b_left};
    bt = {pair_i.b_top[COORD_WIDTH-1], pair_i.b_top};
    ar = al + $signed({2'b00, pair_i.a_width});
    ab = at + $signed({2'b00, pair_i.a_height});
    br = bl + $signed({2'b00, pair_i.b_width});
    bb = bt + $signed({2'b00, pair_i.b_height});

    overlap = !(br <= al || bb <= at || bl >= ar || bt >= ab);
    ct = (bt > at) && (bt < ab);
    cb = (bb > at) && (bb < ab);
    cl = (bl > al) && (bl < ar);
    cr = (br > al) && (br < ar);
    ok = {cr, cl, cb, ct};

    // Every strip that qualifies is narrower than A, so its extent fits the size width.
    d_top   = {bt[EDGE_W-1], bt} - {at[EDGE_W-1], at};
    d_bot   = {ab[EDGE_W-1], ab} - {bb[EDGE_W-1], bb};
    d_left  = {bl[EDGE_W-1], bl} - {al[EDGE_W-1], al};
    d_right = {ar[EDGE_W-1], ar} - {br[EDGE_W-1], br};
    s_top   = d_top[SIZE_W-1:0];
    s_bot   = d_bot[SIZE_W-1:0];
    s_left  = d_left[SIZE_W-1:0];
    s_right = d_right[SIZE_W-1:0];

    if (ct && cb && !cl && !cr) begin
      val[0] = AREA_W'(s_top);
      val[1] = AREA_W'(s_bot);
      val[2] = '0;
      val[3] = '0;
    end else if (cl && cr && !ct && !cb) begin
      val[0] = '0;
      val[1] = '0;
      val[2] = AREA_W'(s_left);
      val[3] = AREA_W'(s_right);
    end else begin
      val[0] = pair_i.a_width * s_top;
      val[1] = pair_i.a_width * s_bot;
      val[2] = s_left * pair_i.a_height;
      val[3] = s_right * pair_i.a_height;
    end

    // Later candidates win ties, so the current best only holds when strictly larger.
    best = 2'd0;
    have = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (ok[i]) begin
        if (!have || !(val[best] > val[i])) begin
          best = 2'(i);
        end
        have = 1'b1;
      end
    end

    res_o.out_left   = al;
    res_o.out_top    = at;
    res_o.out_width  = pair_i.a_width;
    res_o.out_height = pair_i.a_height;
    res_o.part_kept  = KEPT_NONE;
    if (overlap) begin
      if (!have) begin
        res_o.out_width  = '0;
        res_o.out_height = '0;
        res_o.part_kept  = KEPT_EMPTY;
      end else begin
        case (best)
          2'd0: begin
            res_o.out_height = s_top;
            res_o.part_kept  = KEPT_TOP;
          end
          2'd1: begin
            res_o.out_top    = bb;
            res_o.out_height = s_bot;
            res_o.part_kept  = KEPT_BOTTOM;
          end
          2'd2: begin
            res_o.out_width  = s_left;
            res_o.part_kept  = KEPT_LEFT;
          end
          default: begin
            res_o.out_left   = br;
            res_o.out_width  = s_right;
            res_o.part_kept  = KEPT_RIGHT;
          end
        endcase
      end
    end
  end

endmodule

### design/rect_difference_largest_part.sv
// Returns the largest axis-aligned part of rectangle A left uncovered by rectangle B, with a
// code saying which strip was kept. One request is taken every cycle while results drain; a
// result passes two registers: the input register takes the request at the accepting edge and
// the result register takes the result once it can advance, which back-pressure can delay.
// Between them is one combinational pass that forms the edges, four strip areas in parallel
// multipliers and a short compare chain. Back-pressure on the result side stalls the input
// register only when both registers are full.
module rect_difference_largest_part (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // a_left, a_top, a_width, a_height, b_left, b_top, b_width, b_height, zero padding
  input  logic [rdlp_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // out_left, out_top, out_width, out_height
  output logic [rdlp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // part_kept
  output logic [rdlp_pkg::PART_W-1:0]       m_axis_tuser_o
);
  import rdlp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic       out_valid_q, out_valid_d;
  logic       out_adv, in_adv;
  rect_pair_t in_q;
  rect_res_t  res_d, res_q;

  assign out_adv         = !out_valid_q || m_axis_tready_i;
  assign in_adv          = !in_valid_q || out_adv;
  assign s_axis_tready_o = in_adv;

  assign in_valid_d  = in_adv ? s_axis_tvalid_i : in_valid_q;
  assign out_valid_d = out_adv ? in_valid_q : out_valid_q;

  rdlp_core u_core (
    .pair_i (in_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv && s_axis_tvalid_i) begin
      in_q <= rect_pair_t'(s_axis_tdata_i[IN_BITS-1:0]);
    end
    if (out_adv && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_TDATA_W'(res_q[OUT_BITS-1:0]);
  assign m_axis_tuser_o  = res_q.part_kept;

`ifndef SYNTHESIS
  a_part_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.part_kept <= KEPT_EMPTY))
    else $error("result carries a part code beyond the empty code");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.part_kept == KEPT_EMPTY) |->
      (res_q.out_width == '0 && res_q.out_height == '0))
    else $error("empty result has a non-zero size");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("request taken while both registers are held");

  a_accept_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> in_valid_q)
    else $error("accepted request did not reach the input register");
`endif

endmodule

### tb/tb_rect_difference_largest_part.sv
`timescale 1ns / 100ps

module tb_rect_difference_largest_part;
  import rdlp_pkg::*;

  localparam int unsigned NUM_RANDOM   = 1330;
  localparam int unsigned DRAIN_AT     = 800;
  localparam int unsigned HOLD_AT      = 400;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned TAIL_CYCLES  = 8;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned MAX_REPORTS  = 10;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [IN_TDATA_W-1:0]   s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_tdata;
  logic [PART_W-1:0]       m_tuser;

  rect_pair_t pending_pairs[$];
  rect_res_t  strips_due[$];
  int unsigned pairs_sent = 0;
  int unsigned strips_got = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;

  rect_difference_largest_part dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Largest uncovered strip of A, with the tie rules: a later candidate wins unless the
  // current best is strictly larger, and pure top/bottom or left/right cases compare extents.
  function automatic rect_res_t predict_strip(rect_pair_t p);
    longint al, at, aw, ah, bl, bt, bw, bh, ar, ab, br, bb;
    longint ol, ot, ow, oh;
    longint area[4];
    bit     cand[4];
    int     best;
    bit     found;
    part_e  part;
    rect_res_t r;
    al = $signed(p.a_left);
    at = $signed(p.a_top);
    aw = p.a_width;
    ah = p.a_height;
    bl = $signed(p.b_left);
    bt = $signed(p.b_top);
    bw = p.b_width;
    bh = p.b_height;
    ar = al + aw;
    ab = at + ah;
    br = bl + bw;
    bb = bt + bh;
    ol = al;
    ot = at;
    ow = aw;
    oh = ah;
    part = KEPT_NONE;
    if (!(br <= al || bb <= at || bl >= ar || bt >= ab)) begin
      cand[0] = (bt > at) && (bt < ab);
      cand[1] = (bb > at) && (bb < ab);
      cand[2] = (bl > al) && (bl < ar);
      cand[3] = (br > al) && (br < ar);
      if (cand[0] && cand[1] && !cand[2] && !cand[3]) begin
        area[0] = bt - at;
        area[1] = ab - bb;
        area[2] = 0;
        area[3] = 0;
      end else if (cand[2] && cand[3] && !cand[0] && !cand[1]) begin
        area[0] = 0;
        area[1] = 0;
        area[2] = bl - al;
        area[3] = ar - br;
      end else begin
        area[0] = aw * (bt - at);
        area[1] = aw * (ab - bb);
        area[2] = (bl - al) * ah;
        area[3] = (ar - br) * ah;
      end
      best = 0;
      found = 1'b0;
      for (int i = 0; i < 4; i++) begin
        if (cand[i]) begin
          if (!found || !(area[best] > area[i])) best = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        ow = 0;
        oh = 0;
        part = KEPT_EMPTY;
      end else if (best == 0) begin
        oh = bt - at;
        part = KEPT_TOP;
      end else if (best == 1) begin
        ot = bb;
        oh = ab - bb;
        part = KEPT_BOTTOM;
      end else if (best == 2) begin
        ow = bl - al;
        part = KEPT_LEFT;
      end else begin
        ol = br;
        ow = ar - br;
        part = KEPT_RIGHT;
      end
    end
    r.out_left   = ol[EDGE_W-1:0];
    r.out_top    = ot[EDGE_W-1:0];
    r.out_width  = ow[SIZE_W-1:0];
    r.out_height = oh[SIZE_W-1:0];
    r.part_kept  = part;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 32767);
    if (r < 15) return 0;
    if (r < 22) return 32767 - $urandom_range(0, 40);
    return $urandom_range(1, 200);
  endfunction

  function automatic rect_pair_t make_pair(int al, int at, int aw, int ah,
                                           int bl, int bt, int bw, int bh);
    rect_pair_t p;
    p.a_left   = al[COORD_WIDTH-1:0];
    p.a_top    = at[COORD_WIDTH-1:0];
    p.a_width  = aw[SIZE_W-1:0];
    p.a_height = ah[SIZE_W-1:0];
    p.b_left   = bl[COORD_WIDTH-1:0];
    p.b_top    = bt[COORD_WIDTH-1:0];
    p.b_width  = bw[SIZE_W-1:0];
    p.b_height = bh[SIZE_W-1:0];
    return p;
  endfunction

  // Mostly B is placed around or near A, often with edges inside A; the rest is raw noise.
  function automatic rect_pair_t random_pair();
    int unsigned r;
    int al, at, aw, ah, bl, bt, bw, bh, mx, my;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      return make_pair($urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom);
    end
    aw = pick_size();
    ah = pick_size();
    al = $signed(16'($urandom));
    at = $signed(16'($urandom));
    if (r < 30) begin
      mx = $urandom_range(0, 6);
      my = $urandom_range(0, 6);
      bl = al - mx;
      bt = at - my;
      bw = aw + 2 * mx;
      bh = ah + 2 * my;
      if (bw > 32767) bw = 32767;
      if (bh > 32767) bh = 32767;
    end else begin
      bl = al + $urandom_range(0, aw + aw / 2 + 4) - (aw / 4 + 2);
      bt = at + $urandom_range(0, ah + ah / 2 + 4) - (ah / 4 + 2);
      bw = $urandom_range(0, aw + 8);
      bh = $urandom_range(0, ah + 8);
    end
    return make_pair(al, at, aw, ah, bl, bt, bw, bh);
  endfunction

  // Driver: holds a request until it is taken, then in most phases waits out a random gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        strips_due.push_back(predict_strip(pending_pairs[0]));
        void'(pending_pairs.pop_front());
        pairs_sent++;
        if (((pairs_sent / 200) % 3) != 2) send_gap = pick_gap();
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_pairs.size() > 0 &&
                     !(pairs_sent == DRAIN_AT && strips_got != pairs_sent)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= IN_TDATA_W'(pending_pairs[0]);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure, with one long hold-off once a few hundred results are in.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (!hold_done && strips_got >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (((cycle_cnt / 1500) % 3) != 1 && $urandom_range(0, 3) == 0) recv_gap = pick_gap();
      end
    end
  end

  // Monitor: each result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    rect_res_t want;
    logic [EDGE_W-1:0] got_left, got_top;
    logic [SIZE_W-1:0] got_width, got_height;
    if (rst_ni && m_tvalid && m_tready) begin
      got_left   = m_tdata[EDGE_W-1:0];
      got_top    = m_tdata[2*EDGE_W-1:EDGE_W];
      got_width  = m_tdata[2*EDGE_W+SIZE_W-1:2*EDGE_W];
      got_height = m_tdata[2*EDGE_W+2*SIZE_W-1:2*EDGE_W+SIZE_W];
      strips_got <= strips_got + 1;
      if (strips_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("result with no request pending: tdata %h tuser %0d", m_tdata, m_tuser);
      end else begin
        want = strips_due.pop_front();
        if (got_left !== want.out_left || got_top !== want.out_top ||
            got_width !== want.out_width || got_height !== want.out_height ||
            m_tuser !== want.part_kept) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch at result %0d: expected l %0d t %0d w %0d h %0d part %0d,",
                     strips_got, $signed(want.out_left), $signed(want.out_top),
                     want.out_width, want.out_height, want.part_kept,
                     " got l %0d t %0d w %0d h %0d part %0d",
                     $signed(got_left), $signed(got_top), got_width, got_height, m_tuser);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("** rect_difference_largest_part: FAILED **");
      $finish;
    end
  end

  initial begin
    // No overlap: all zero, and B's right edge touching A's left edge.
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, -20, 10, 20, 50));
    // B covers A entirely.
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                      -32768, -32768, 32767, 32767));
    pending_pairs.push_back(make_pair(-100, -100, 50, 50, -32768, -32768, 32767, 32767));
    // Only left and right edges inside: widths compared, and a tie.
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 10, -10, 20, 200));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 40, -10, 20, 200));
    // Only top and bottom edges inside: heights compared, and a tie.
    pending_pairs.push_back(make_pair(0, 0, 100, 100, -10, 10, 200, 20));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, -10, 40, 200, 20));
    // Every edge of B inside A: equal areas, and a clear winner on the right and on the bottom.
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 40, 40, 20, 20));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 10, 60, 20, 20));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 60, 10, 20, 20));
    // A corner of A covered: top and left tie on area.
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 50, 50, 100, 100));
    // A single edge inside.
    pending_pairs.push_back(make_pair(0, 0, 100, 100, -10, 50, 200, 200));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 70, -10, 200, 200));
    // Zero sizes.
    pending_pairs.push_back(make_pair(0, 0, 0, 100, -5, 30, 10, 10));
    pending_pairs.push_back(make_pair(0, 0, 100, 100, 50, 50, 0, 0));
    // Coordinate extremes and large areas.
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767,
                                      32767, 32767, 32767, 32767));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767,
                                      -32768, -32768, 32767, 32767));
    pending_pairs.push_back(make_pair(-32768, -32768, 32767, 32767, 0, 0, 1, 1));
    pending_pairs.push_back(make_pair(32767, 32767, 32767, 32767, 32768, 32768, 1, 1));
    for (int i = 0; i < NUM_RANDOM; i++) pending_pairs.push_back(random_pair());

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_pairs.size() != 0 || strips_due.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && strips_due.size() == 0) begin
      $display("** rect_difference_largest_part: PASSED **");
    end else begin
      $display("** rect_difference_largest_part: FAILED **");
    end
    $finish;
  end

endmodule
